// ===== src/acd_pkg.sv =====
// shared constants and controller/datapath interface types for the ascii command decoder
`timescale 1ns / 1ps

package acd_pkg;

	localparam int PAYLOAD_MAX = 9;
	localparam int LED_COUNT   = 5;

	localparam int BYTE_W    = 8;
	localparam int LED_NUM_W = 3;
	localparam int IDX_W     = $clog2(PAYLOAD_MAX);
	localparam int REM_W     = $clog2(PAYLOAD_MAX + 1);
	localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int OUT_W     = BYTE_W + LED_NUM_W + LED_COUNT;
	localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [BYTE_W-1:0] CH_U    = 8'h75;
	localparam logic [BYTE_W-1:0] CH_I    = 8'h69;
	localparam logic [BYTE_W-1:0] CH_L    = 8'h6C;
	localparam logic [BYTE_W-1:0] CH_TWO  = 8'h32;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;
	localparam logic [BYTE_W-1:0] CH_LED_TOP  = CH_ZERO + BYTE_W'(LED_COUNT);
	localparam logic [BYTE_W-1:0] CH_SIZE_TOP = CH_ZERO + BYTE_W'(PAYLOAD_MAX);

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_LED     = 1'b1;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic load_tick;
		logic set_led;
		logic load_size;
		logic store_byte;
		logic emit;
	} acd_ctl_t;

	typedef struct packed {
		logic out_free;
		logic pending_any;
		logic is_u;
		logic is_i;
		logic is_l;
		logic is_two;
		logic led_ok;
		logic size_ok;
		logic rem_one;
		logic emit_last;
	} acd_sts_t;

endpackage

// ===== src/acd_ctrl.sv =====
// parser and sequencing state machine of the ascii command decoder
`timescale 1ns / 1ps

module acd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	input  acd_pkg::acd_sts_t sts,
	output acd_pkg::acd_ctl_t ctl
);
	import acd_pkg::*;

	typedef enum logic [2:0] {
		P_IDLE,
		P_PRE1,
		P_PRE2,
		P_LED,
		P_PORT,
		P_SIZE,
		P_DATA,
		P_EMIT
	} parse_t;

	parse_t state_q;
	parse_t state_d;
	logic   accept;

	assign in_ready = (state_q != P_EMIT) && sts.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		if (state_q == P_EMIT) begin
			if (sts.out_free) begin
				ctl.emit = 1'b1;
				if (sts.emit_last) begin
					state_d = P_IDLE;
				end
			end
		end else if (accept) begin
			if (in_cmd == CMD_TICK) begin
				ctl.load_tick = sts.pending_any;
			end else begin
				case (state_q)
					P_PRE1: begin
						state_d = sts.is_i ? P_PRE2 : P_IDLE;
					end
					P_PRE2: begin
						if (sts.is_l) begin
							state_d = P_LED;
						end else if (sts.is_u) begin
							state_d = P_PORT;
						end
					end
					P_LED: begin
						ctl.set_led = sts.led_ok;
						state_d     = P_IDLE;
					end
					P_PORT: begin
						state_d = sts.is_two ? P_SIZE : P_IDLE;
					end
					P_SIZE: begin
						ctl.load_size = sts.size_ok;
						state_d       = sts.size_ok ? P_DATA : P_IDLE;
					end
					P_DATA: begin
						ctl.store_byte = 1'b1;
						if (sts.rem_one) begin
							state_d = P_EMIT;
						end
					end
					default: begin
						state_d = sts.is_u ? P_PRE1 : P_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/acd_dp.sv =====
// datapath: byte compares, payload store, led registers and output register
`timescale 1ns / 1ps

module acd_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [acd_pkg::BYTE_W-1:0]  rx,
	input  acd_pkg::acd_ctl_t           ctl,
	output acd_pkg::acd_sts_t           sts,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [acd_pkg::OUT_PAD_W-1:0] m_axis_tdata,
	output logic                        m_axis_tuser,
	output logic                        m_axis_tlast
);
	import acd_pkg::*;

	logic [BYTE_W-1:0]    store_q [PAYLOAD_MAX];
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     len_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [LED_COUNT-1:0] pending_q;
	logic [LED_COUNT-1:0] leds_q;

	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic [LED_NUM_W-1:0] out_led_q;
	logic [LED_COUNT-1:0] out_levels_q;
	logic                 out_last_q;

	logic                 sel_found;
	logic [LED_IDX_W-1:0] sel_idx;
	logic [LED_COUNT-1:0] sel_mask;
	logic [LED_COUNT-1:0] set_mask;
	logic [LED_IDX_W-1:0] led_bit;
	logic [IDX_W-1:0]     wr_idx;
	logic [REM_W-1:0]     rd_next;

	// lowest pending led
	always_comb begin
		sel_found = 1'b0;
		sel_idx   = '0;
		for (int i = 0; i < LED_COUNT; i++) begin
			if (!sel_found && pending_q[i]) begin
				sel_found = 1'b1;
				sel_idx   = LED_IDX_W'(i);
			end
		end
	end

	assign sel_mask = LED_COUNT'(1) << sel_idx;
	assign led_bit  = LED_IDX_W'(rx - CH_ONE);
	assign set_mask = LED_COUNT'(1) << led_bit;
	assign wr_idx   = IDX_W'(rem_q - REM_W'(1));
	assign rd_next  = REM_W'(rd_idx_q) + REM_W'(1);

	always_comb begin
		sts.out_free    = !out_valid_q || m_axis_tready;
		sts.pending_any = |pending_q;
		sts.is_u        = (rx == CH_U);
		sts.is_i        = (rx == CH_I);
		sts.is_l        = (rx == CH_L);
		sts.is_two      = (rx == CH_TWO);
		sts.led_ok      = rx inside {[CH_ONE : CH_LED_TOP]};
		sts.size_ok     = rx inside {[CH_ONE : CH_SIZE_TOP]};
		sts.rem_one     = (rem_q == REM_W'(1));
		sts.emit_last   = (rd_next == len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			len_q     <= '0;
			rd_idx_q  <= '0;
			pending_q <= '0;
			leds_q    <= '0;
		end else begin
			if (ctl.load_tick) begin
				pending_q <= pending_q & ~sel_mask;
				leds_q    <= leds_q ^ sel_mask;
			end else if (ctl.set_led) begin
				pending_q <= pending_q | set_mask;
			end
			if (ctl.load_size) begin
				len_q    <= REM_W'(rx - CH_ZERO);
				rem_q    <= REM_W'(rx - CH_ZERO);
				rd_idx_q <= '0;
			end else if (ctl.store_byte) begin
				rem_q <= rem_q - REM_W'(1);
			end
			if (ctl.emit) begin
				rd_idx_q <= IDX_W'(rd_next);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.store_byte) begin
			store_q[wr_idx] <= rx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_tick || ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_tick) begin
			out_kind_q   <= KIND_LED;
			out_byte_q   <= '0;
			out_led_q    <= LED_NUM_W'(sel_idx) + LED_NUM_W'(1);
			out_levels_q <= leds_q ^ sel_mask;
			out_last_q   <= 1'b1;
		end else if (ctl.emit) begin
			out_kind_q   <= KIND_PAYLOAD;
			out_byte_q   <= store_q[rd_idx_q];
			out_led_q    <= '0;
			out_levels_q <= leds_q;
			out_last_q   <= (rd_next == len_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OUT_PAD_W'({out_levels_q, out_led_q, out_byte_q});

endmodule

// ===== src/ascii_command_decoder.sv =====
// Decodes a host byte stream of "ui" prefixed commands: "uil<d>" marks led d as
// pending, "uiu2<n>" followed by n payload bytes forwards them as a burst with the
// last received byte first, and a service tick toggles and reports the lowest
// pending led. A host byte or tick is taken whenever the output register is free and
// no payload is being read out: the final byte of a payload holds off input while
// the n-entry payload store is read out, one result per cycle while the output is
// not stalled, through the single output register. Results are buffered in one output
// register, so the next item is taken in the cycle its predecessor's result is handed
// over.
`timescale 1ns / 1ps

module ascii_command_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [acd_pkg::BYTE_W-1:0]    s_axis_tdata,  // rx_byte
	input  logic                          s_axis_tuser,  // cmd
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [acd_pkg::OUT_PAD_W-1:0] m_axis_tdata,  // payload_byte, led_number, led_levels
	output logic                          m_axis_tuser,  // kind
	output logic                          m_axis_tlast
);
	import acd_pkg::*;

	acd_ctl_t ctl;
	acd_sts_t sts;

	acd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	acd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (s_axis_tdata),
		.ctl           (ctl),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== bench/acd_result_checker.sv =====
// result checker for the ascii command decoder: predicts each item's results and compares them
`timescale 1ns / 1ps

module acd_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [acd_pkg::BYTE_W-1:0]    in_data,
	input  logic                          in_user,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [acd_pkg::OUT_PAD_W-1:0] out_data,
	input  logic                          out_user,
	input  logic                          out_last,
	output int                            errors,
	output int                            waiting,
	output int                            checked,
	output int                            toggles
);

	import acd_pkg::*;

	typedef enum logic [2:0] {
		P_IDLE,
		P_GOT_U,
		P_PREFIX,
		P_LED,
		P_PORT,
		P_SIZE,
		P_PAYLOAD
	} parse_t;

	typedef struct {
		logic                 kind;
		logic [BYTE_W-1:0]    payload;
		logic [LED_NUM_W-1:0] led;
		logic [LED_COUNT-1:0] levels;
		logic                 last;
	} report_t;

	parse_t               parse;
	int                   remaining;
	int                   burst;
	logic [BYTE_W-1:0]    burst_store [PAYLOAD_MAX];
	logic [LED_COUNT-1:0] pending;
	logic [LED_COUNT-1:0] leds;
	report_t              due_results [$];
	int                   err_count = 0;
	int                   seen_count = 0;
	int                   toggle_count = 0;

	function automatic void queue_report(input logic kind, input logic [BYTE_W-1:0] pb,
			input int led, input logic last);
		report_t r;
		r.kind    = kind;
		r.payload = pb;
		r.led     = LED_NUM_W'(led);
		r.levels  = leds;
		r.last    = last;
		due_results.push_back(r);
	endfunction

	function automatic void service_led();
		logic done;
		done = 1'b0;
		for (int i = 0; i < LED_COUNT; i++) begin
			if (!done && pending[i]) begin
				pending[i] = 1'b0;
				leds[i]    = ~leds[i];
				queue_report(KIND_LED, '0, i + 1, 1'b1);
				done = 1'b1;
			end
		end
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		case (parse)
			P_GOT_U: begin
				parse = (b == CH_I) ? P_PREFIX : P_IDLE;
			end
			P_PREFIX: begin
				if (b == CH_L)
					parse = P_LED;
				else if (b == CH_U)
					parse = P_PORT;
			end
			P_LED: begin
				if (b >= CH_ONE && b <= CH_LED_TOP)
					pending[b - CH_ONE] = 1'b1;
				parse = P_IDLE;
			end
			P_PORT: begin
				parse = (b == CH_TWO) ? P_SIZE : P_IDLE;
			end
			P_SIZE: begin
				if (b >= CH_ONE && b <= CH_SIZE_TOP) begin
					burst     = int'(b - CH_ZERO);
					remaining = burst;
					parse     = P_PAYLOAD;
				end else begin
					parse = P_IDLE;
				end
			end
			P_PAYLOAD: begin
				if (remaining == 0 || remaining > PAYLOAD_MAX) begin
					parse = P_IDLE;
				end else begin
					remaining--;
					burst_store[remaining] = b;
					if (remaining == 0) begin
						// last byte received goes out first
						for (int i = 0; i < burst; i++)
							queue_report(KIND_PAYLOAD, burst_store[i], 0, i + 1 == burst);
						parse = P_IDLE;
					end
				end
			end
			default: begin
				parse = (b == CH_U) ? P_GOT_U : P_IDLE;
			end
		endcase
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	function automatic void check_report();
		report_t r;
		if (due_results.size() == 0) begin
			$error("result with nothing expected: kind %0d, data %0h, last %0d",
				out_user, out_data, out_last);
			err_count++;
		end else begin
			r = due_results.pop_front();
			compare_field("kind", r.kind, out_user);
			compare_field("payload_byte", r.payload, out_data[BYTE_W-1:0]);
			compare_field("led_number", r.led, out_data[BYTE_W +: LED_NUM_W]);
			compare_field("led_levels", r.levels, out_data[BYTE_W + LED_NUM_W +: LED_COUNT]);
			compare_field("last", r.last, out_last);
			seen_count++;
			if (r.kind == KIND_LED)
				toggle_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse     = P_IDLE;
			remaining = 0;
			burst     = 0;
			pending   = '0;
			leds      = '0;
			due_results.delete();
			errors  <= err_count;
			waiting <= 0;
			checked <= seen_count;
			toggles <= toggle_count;
		end else begin
			if (out_valid && out_ready)
				check_report();
			if (in_valid && in_ready) begin
				if (in_user == CMD_TICK)
					service_led();
				else
					decode_byte(in_data);
			end
			errors  <= err_count;
			waiting <= due_results.size();
			checked <= seen_count;
			toggles <= toggle_count;
		end
	end

endmodule

// ===== bench/ascii_command_decoder_test.sv =====
// testbench top for the ascii command decoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module ascii_command_decoder_test;

	import acd_pkg::*;

	localparam int ITEM_TARGET    = 330;
	localparam int QUIET_TAIL     = 60;
	localparam int SETTLE_CYCLES  = 24;
	localparam int WATCHDOG_LIMIT = 1000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_PAD_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;

	int   errors;
	int   waiting;
	int   checked;
	int   toggles;
	int   items_sent = 0;
	int   idle_cycles = 0;
	logic src_gaps = 1'b1;
	logic sink_stalls = 1'b1;

	ascii_command_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	acd_result_checker results (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast),
		.errors    (errors),
		.waiting   (waiting),
		.checked   (checked),
		.toggles   (toggles)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic c, input logic [BYTE_W-1:0] b);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, BYTE_W'($urandom_range(0, 255)));
	endtask

	// random ticks land in the middle of commands
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if ($urandom_range(0, 11) == 0)
			send_tick();
		send_item(CMD_BYTE, b);
	endtask

	task automatic send_prefix();
		send_byte(CH_U);
		send_byte(CH_I);
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 2)) send_byte(BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic led_command();
		send_prefix();
		send_byte(CH_L);
		if ($urandom_range(0, 5) != 0)
			send_byte(CH_ONE + BYTE_W'($urandom_range(0, LED_COUNT - 1)));
		else
			send_byte(BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic payload_command();
		int n;
		send_prefix();
		send_byte(CH_U);
		if ($urandom_range(0, 9) == 0) begin
			send_byte(BYTE_W'($urandom_range(0, 255)));
		end else begin
			send_byte(CH_TWO);
			if ($urandom_range(0, 9) == 0) begin
				send_byte(BYTE_W'($urandom_range(0, 255)));
			end else begin
				n = ($urandom_range(0, 7) == 0) ? PAYLOAD_MAX : $urandom_range(1, 4);
				send_byte(CH_ZERO + BYTE_W'(n));
				repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_BYTE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick with nothing pending
		send_item(CMD_TICK, 8'hFF);
		// led 1
		send_item(CMD_BYTE, CH_U);
		send_item(CMD_BYTE, CH_I);
		send_item(CMD_BYTE, CH_L);
		send_item(CMD_BYTE, CH_ONE);
		// ignored byte after the prefix, then the top led
		send_item(CMD_BYTE, CH_U);
		send_item(CMD_BYTE, CH_I);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, CH_L);
		send_item(CMD_BYTE, CH_LED_TOP);
		// size digit zero aborts
		send_item(CMD_BYTE, CH_U);
		send_item(CMD_BYTE, CH_I);
		send_item(CMD_BYTE, CH_U);
		send_item(CMD_BYTE, CH_TWO);
		send_item(CMD_BYTE, CH_ZERO);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		// full size burst with a tick in the middle
		send_item(CMD_BYTE, CH_U);
		send_item(CMD_BYTE, CH_I);
		send_item(CMD_BYTE, CH_U);
		send_item(CMD_BYTE, CH_TWO);
		send_item(CMD_BYTE, CH_SIZE_TOP);
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'hA5);
		send_item(CMD_TICK, 8'h5A);
		send_item(CMD_BYTE, 8'h5A);
		send_item(CMD_BYTE, 8'h01);
		send_item(CMD_BYTE, 8'h80);
		send_item(CMD_BYTE, 8'h7F);
		send_item(CMD_BYTE, 8'hFE);
		send_item(CMD_BYTE, 8'h55);

		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
				src_gaps    = 1'b0;
				sink_stalls = 1'b0;
			end else if ($urandom_range(0, 11) == 0) begin
				src_gaps    = $urandom_range(0, 1);
				sink_stalls = $urandom_range(0, 1);
			end
			case ($urandom_range(0, 9))
				0, 1, 2: led_command();
				3, 4, 5: payload_command();
				6, 7:    repeat ($urandom_range(1, 3)) send_tick();
				8: begin
					send_byte(CH_U);
					if ($urandom_range(0, 1) == 0) begin
						send_byte(BYTE_W'($urandom_range(0, 255)));
					end else begin
						send_byte(CH_I);
						repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
					end
				end
				default: send_byte(BYTE_W'($urandom_range(0, 255)));
			endcase
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d input items: %0d results checked, %0d of them led toggles",
			items_sent, checked, toggles);
		$display("and %0d forwarded payload bytes", checked - toggles);
		if (errors == 0 && waiting == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
